// File: rtl/gpl_pkg.sv
package gpl_pkg;

    localparam int unsigned PIN_COUNT = 16;

    localparam logic [31:0] CFG_RESET = 32'h4444_4444;
    localparam int unsigned KEY_POS   = 16;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] SEL_CRL    = 3'd0;
    localparam logic [2:0] SEL_CRH    = 3'd1;
    localparam logic [2:0] SEL_IDR    = 3'd2;
    localparam logic [2:0] SEL_ODR    = 3'd3;
    localparam logic [2:0] SEL_BSRR   = 3'd4;
    localparam logic [2:0] SEL_BRR    = 3'd5;
    localparam logic [2:0] SEL_LCKR   = 3'd6;
    localparam logic [2:0] SEL_UNUSED = 3'd7;

    typedef enum logic [1:0] {
        LOCK_IDLE  = 2'd0,
        LOCK_KEY1  = 2'd1,
        LOCK_KEY0  = 2'd2,
        LOCK_KEY1B = 2'd3
    } lock_step_t;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  reg_select;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic        lock_active;
    } rsp_t;

endpackage

// File: rtl/gpl_core.sv
module gpl_core #(
    parameter int unsigned PIN_COUNT = gpl_pkg::PIN_COUNT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  gpl_pkg::req_t item,
    output gpl_pkg::rsp_t result
);

    localparam logic [15:0] PinMask = 16'((17'd1 << PIN_COUNT) - 17'd1);

    logic [31:0]         cfg_low_reg, cfg_low_next;
    logic [31:0]         cfg_high_reg, cfg_high_next;
    logic [15:0]         latch_reg, latch_next;
    logic [15:0]         lock_bits_reg, lock_bits_next;
    logic                lock_key_reg, lock_key_next;
    gpl_pkg::lock_step_t lock_step_reg, lock_step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_low_reg   <= gpl_pkg::CFG_RESET;
            cfg_high_reg  <= gpl_pkg::CFG_RESET;
            latch_reg     <= '0;
            lock_bits_reg <= '0;
            lock_key_reg  <= 1'b0;
            lock_step_reg <= gpl_pkg::LOCK_IDLE;
        end
        else if (take)
        begin
            cfg_low_reg   <= cfg_low_next;
            cfg_high_reg  <= cfg_high_next;
            latch_reg     <= latch_next;
            lock_bits_reg <= lock_bits_next;
            lock_key_reg  <= lock_key_next;
            lock_step_reg <= lock_step_next;
        end
    end

    logic [31:0] frozen_low;
    logic [31:0] frozen_high;
    logic [15:0] wr_lo;
    logic [15:0] wr_hi;
    logic [15:0] lck_bits;
    logic        key_bit;
    logic        same_bits;
    logic [31:0] rd;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            frozen_low[4*i +: 4]  = {4{lock_key_reg & lock_bits_reg[i]}};
            frozen_high[4*i +: 4] = {4{lock_key_reg & lock_bits_reg[8+i]}};
        end
    end

    always_comb
    begin
        wr_lo     = item.write_data[15:0];
        wr_hi     = item.write_data[31:16];
        lck_bits  = wr_lo & PinMask;
        key_bit   = item.write_data[gpl_pkg::KEY_POS];
        same_bits = (lck_bits == lock_bits_reg);

        cfg_low_next   = cfg_low_reg;
        cfg_high_next  = cfg_high_reg;
        latch_next     = latch_reg;
        lock_bits_next = lock_bits_reg;
        lock_key_next  = lock_key_reg;
        lock_step_next = lock_step_reg;
        rd             = '0;

        if (item.opcode == gpl_pkg::OP_WRITE)
        begin
            case (item.reg_select)
                gpl_pkg::SEL_CRL:
                    cfg_low_next = (cfg_low_reg & frozen_low)
                                 | (item.write_data & ~frozen_low);
                gpl_pkg::SEL_CRH:
                    cfg_high_next = (cfg_high_reg & frozen_high)
                                  | (item.write_data & ~frozen_high);
                gpl_pkg::SEL_ODR:
                    latch_next = wr_lo & PinMask;
                gpl_pkg::SEL_BSRR:
                    latch_next = ((latch_reg & ~wr_hi) | wr_lo) & PinMask;
                gpl_pkg::SEL_BRR:
                    latch_next = latch_reg & ~wr_lo & PinMask;
                gpl_pkg::SEL_LCKR:
                begin
                    if (lock_key_reg)
                    begin
                        lock_step_next = gpl_pkg::LOCK_IDLE;
                    end
                    else
                    begin
                        lock_bits_next = lck_bits;
                        if (lock_step_reg == gpl_pkg::LOCK_KEY1 && !key_bit && same_bits)
                            lock_step_next = gpl_pkg::LOCK_KEY0;
                        else if (lock_step_reg == gpl_pkg::LOCK_KEY0 && key_bit && same_bits)
                            lock_step_next = gpl_pkg::LOCK_KEY1B;
                        else if (key_bit)
                            lock_step_next = gpl_pkg::LOCK_KEY1;
                        else
                            lock_step_next = gpl_pkg::LOCK_IDLE;
                    end
                end
                default:
                    ;
            endcase
        end
        else
        begin
            case (item.reg_select)
                gpl_pkg::SEL_CRL:  rd = cfg_low_reg;
                gpl_pkg::SEL_CRH:  rd = cfg_high_reg;
                gpl_pkg::SEL_IDR:  rd = {16'd0, item.pin_levels & PinMask};
                gpl_pkg::SEL_ODR:  rd = {16'd0, latch_reg};
                gpl_pkg::SEL_LCKR:
                begin
                    // first read after a full sequence still shows the key clear
                    rd = {15'd0, lock_key_reg, lock_bits_reg};
                    if (!lock_key_reg && lock_step_reg == gpl_pkg::LOCK_KEY1B)
                        lock_key_next = 1'b1;
                    lock_step_next = gpl_pkg::LOCK_IDLE;
                end
                default:           rd = '0;
            endcase
        end

        result.read_data   = rd;
        result.pin_drive   = latch_next;
        result.lock_active = lock_key_next;
    end

endmodule

// File: rtl/gpio_port_with_lock.sv
// Channel   Valid      Stall      Payload            Accepted when
// request   req_valid  req_stall  req (gpl_pkg::req_t)  req_valid && !req_stall
// response  rsp_valid  rsp_stall  rsp (gpl_pkg::rsp_t)  rsp_valid && !rsp_stall
//
// One item per cycle sustained while the response is not stalled; each taken item passes
// through the input register, then the result register, before it leaves on the response.
// Register state is updated when an item moves from the input register to the
// result register, so a stalled response holds everything behind it.
// req_stall rises only when both registers are full and rsp_stall is high.
// rst_n clears all valid bits and the port registers at once.
module gpio_port_with_lock #(
    parameter int unsigned PIN_COUNT = gpl_pkg::PIN_COUNT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  gpl_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output gpl_pkg::rsp_t rsp
);

    logic          s1_valid_reg;
    gpl_pkg::req_t s1_item_reg;
    logic          rsp_valid_reg;
    gpl_pkg::rsp_t rsp_item_reg;
    gpl_pkg::rsp_t result;
    logic          advance;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && rsp_valid_reg && rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_item_reg;

    gpl_core #(
        .PIN_COUNT (PIN_COUNT)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (advance),
        .item   (s1_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!req_stall)
                s1_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
            s1_item_reg <= req;
        if (advance)
            rsp_item_reg <= result;
    end

endmodule

// File: rtl/gpl_checker.sv
module gpl_checker #(
    parameter int unsigned PIN_COUNT = gpl_pkg::PIN_COUNT
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input gpl_pkg::rsp_t rsp
);

    localparam logic [15:0] PinMask = 16'((17'd1 << PIN_COUNT) - 17'd1);

    logic [1:0] count_reg;
    logic       seen_lock_reg;
    logic       req_take;
    logic       rsp_take;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            seen_lock_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_reg + 2'(req_take) - 2'(rsp_take);
            if (rsp_take && rsp.lock_active)
                seen_lock_reg <= 1'b1;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count_reg != 2'd0)
        else $error("response with no item in flight");

    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd0 |-> !req_stall)
        else $error("request stalled while empty");

    a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && seen_lock_reg |-> rsp.lock_active)
        else $error("lock key dropped before reset");

    a_absent_pins: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.pin_drive & ~PinMask) == 16'd0)
        else $error("absent pin driven");

endmodule

bind gpio_port_with_lock gpl_checker #(
    .PIN_COUNT (PIN_COUNT)
) u_gpl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] PIN_MASK = (gpl_pkg::PIN_COUNT >= 16) ? 16'hFFFF
                                       : 16'((32'd1 << gpl_pkg::PIN_COUNT) - 32'd1);
    localparam int UNLOCKED_ITEMS = 400;
    localparam int TOTAL_ITEMS    = 775;
    localparam int CALM_ITEMS     = 60;
    localparam int HOLD_CYCLES    = 200;
    localparam int HOLD_AFTER     = 120;
    localparam int LIMIT_CYCLES   = 200000;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    gpl_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    gpl_pkg::rsp_t  rsp;

    // port state as the testbench sees it
    logic [31:0]         cfg_lo;
    logic [31:0]         cfg_hi;
    logic [15:0]         latch;
    logic [15:0]         lck_bits;
    logic                lck_key;
    gpl_pkg::lock_step_t lck_step;

    gpl_pkg::req_t pending_acc[$];
    gpl_pkg::rsp_t expected_rsp[$];
    gpl_pkg::rsp_t predicted;
    gpl_pkg::rsp_t want;

    int errors = 0;
    int cycles = 0;
    int rsp_seen = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit held = 1'b0;
    logic stall_next;

    gpio_port_with_lock u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] frozen_nibbles(input int base);
        logic [31:0] m;
        m = '0;
        if (lck_key)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (lck_bits[base + i])
                    m[4 * i +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

    task automatic lock_write(input logic [31:0] d);
        logic [15:0]         bits;
        logic                k;
        logic                same;
        gpl_pkg::lock_step_t nxt;
        bits = d[15:0] & PIN_MASK;
        k    = d[gpl_pkg::KEY_POS];
        same = (bits == lck_bits);
        if (lck_key)
            lck_step = gpl_pkg::LOCK_IDLE;
        else
        begin
            if (lck_step == gpl_pkg::LOCK_KEY1 && !k && same)
                nxt = gpl_pkg::LOCK_KEY0;
            else if (lck_step == gpl_pkg::LOCK_KEY0 && k && same)
                nxt = gpl_pkg::LOCK_KEY1B;
            else
                nxt = k ? gpl_pkg::LOCK_KEY1 : gpl_pkg::LOCK_IDLE;
            lck_bits = bits;
            lck_step = nxt;
        end
    endtask

    task automatic port_access(input gpl_pkg::req_t a, output gpl_pkg::rsp_t r);
        logic [31:0] rd;
        logic [31:0] f;
        rd = '0;
        if (a.opcode == gpl_pkg::OP_WRITE)
        begin
            case (a.reg_select)
                gpl_pkg::SEL_CRL:
                begin
                    f = frozen_nibbles(0);
                    cfg_lo = (cfg_lo & f) | (a.write_data & ~f);
                end
                gpl_pkg::SEL_CRH:
                begin
                    f = frozen_nibbles(8);
                    cfg_hi = (cfg_hi & f) | (a.write_data & ~f);
                end
                gpl_pkg::SEL_ODR:  latch = a.write_data[15:0] & PIN_MASK;
                // set wins over clear for the same bit
                gpl_pkg::SEL_BSRR:
                    latch = ((latch & ~a.write_data[31:16]) | a.write_data[15:0])
                            & PIN_MASK;
                gpl_pkg::SEL_BRR:  latch = latch & ~a.write_data[15:0] & PIN_MASK;
                gpl_pkg::SEL_LCKR: lock_write(a.write_data);
                default:  ;
            endcase
        end
        else
        begin
            case (a.reg_select)
                gpl_pkg::SEL_CRL: rd = cfg_lo;
                gpl_pkg::SEL_CRH: rd = cfg_hi;
                gpl_pkg::SEL_IDR: rd = {16'h0, a.pin_levels & PIN_MASK};
                gpl_pkg::SEL_ODR: rd = {16'h0, latch};
                gpl_pkg::SEL_LCKR:
                begin
                    // key bit reads back as the old key, so the arming read shows 0
                    rd = {15'h0, lck_key, lck_bits};
                    if (!lck_key && lck_step == gpl_pkg::LOCK_KEY1B)
                        lck_key = 1'b1;
                    lck_step = gpl_pkg::LOCK_IDLE;
                end
                default: rd = '0;
            endcase
        end
        r.read_data   = rd;
        r.pin_drive   = latch;
        r.lock_active = lck_key;
    endtask

    function automatic gpl_pkg::req_t acc(input logic op, input logic [2:0] sel,
                                          input logic [31:0] d, input logic [15:0] p);
        gpl_pkg::req_t a;
        a.opcode     = op;
        a.reg_select = sel;
        a.write_data = d;
        a.pin_levels = p;
        return a;
    endfunction

    function automatic gpl_pkg::req_t any_access(input bit lckr_ok);
        logic [2:0]  sel;
        logic [31:0] d;
        int          pick;
        sel = 3'($urandom_range(0, 7));
        if (!lckr_ok && sel == gpl_pkg::SEL_LCKR)
            sel = 3'($urandom_range(0, 5));
        pick = $urandom_range(0, 15);
        if (pick == 0)
            d = 32'hFFFF_FFFF;
        else if (pick == 1)
            d = '0;
        else
            d = $urandom();
        return acc(1'($urandom_range(0, 1)), sel, d, 16'($urandom()));
    endfunction

    task automatic queue_filler();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) pending_acc.push_back(any_access(1'b0));
    endtask

    // key 1 / key 0 / key 1 / read; an incomplete run breaks it at a random step
    task automatic queue_lock_seq(input bit complete);
        logic [15:0] bits;
        logic [15:0] other;
        int          mode;
        bits  = 16'($urandom());
        other = bits ^ (16'h1 << $urandom_range(0, 15));
        mode  = complete ? 0 : $urandom_range(1, 5);
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_LCKR,
                                  {15'($urandom()), 1'b1, bits}, 16'($urandom())));
        queue_filler();
        if (mode == 2)
        begin
            pending_acc.push_back(acc(gpl_pkg::OP_READ, gpl_pkg::SEL_LCKR,
                                      $urandom(), 16'($urandom())));
            return;
        end
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_LCKR,
                                  {15'($urandom()), 1'b0, (mode == 1) ? other : bits},
                                  16'($urandom())));
        queue_filler();
        if (mode == 3)
        begin
            pending_acc.push_back(acc(gpl_pkg::OP_READ, gpl_pkg::SEL_LCKR,
                                      $urandom(), 16'($urandom())));
            return;
        end
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_LCKR,
                                  {15'($urandom()), (mode == 4) ? 1'b0 : 1'b1, bits},
                                  16'($urandom())));
        queue_filler();
        if (mode == 5)
            pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_LCKR,
                                      {15'($urandom()), 1'b1, bits}, 16'($urandom())));
        pending_acc.push_back(acc(gpl_pkg::OP_READ, gpl_pkg::SEL_LCKR,
                                  $urandom(), 16'($urandom())));
        queue_filler();
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            gap_left  = 0;
            cfg_lo    = gpl_pkg::CFG_RESET;
            cfg_hi    = gpl_pkg::CFG_RESET;
            latch     = '0;
            lck_bits  = '0;
            lck_key   = 1'b0;
            lck_step  = gpl_pkg::LOCK_IDLE;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                port_access(req, predicted);
                expected_rsp.push_back(predicted);
                pending_acc.delete(0);
            end
            if (req_valid && req_stall)
            begin
                // hold the stalled item
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_acc.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(0, 12);
                req_valid <= 1'b0;
            end
            else if (pending_acc.size() != 0)
            begin
                req_valid <= 1'b1;
                req       <= pending_acc[0];
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response monitor and stall generator
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_seen++;
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual %h", $time, rsp);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        errors++;
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want.read_data, rsp.read_data);
                    end
                    if (rsp.pin_drive !== want.pin_drive)
                    begin
                        errors++;
                        $display("%0t: pin_drive expected %h actual %h",
                                 $time, want.pin_drive, rsp.pin_drive);
                    end
                    if (rsp.lock_active !== want.lock_active)
                    begin
                        errors++;
                        $display("%0t: lock_active expected %b actual %b",
                                 $time, want.lock_active, rsp.lock_active);
                    end
                end
            end
            // one long hold-off lets the block fill up and stall its input
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (!held && rsp_seen >= HOLD_AFTER)
            begin
                held       = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                stall_next = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                stall_next = 1'b1;
            end
            else if (pending_acc.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            rsp_stall <= stall_next;
        end
    end

    initial
    begin
        // directed part
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_CRL,
                                  32'h0, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_CRH,
                                  32'hFFFF_FFFF, 16'hFFFF));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_CRL,
                                  32'hFFFF_FFFF, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_CRL,
                                  32'h0, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_CRH,
                                  32'h0, 16'hFFFF));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_CRH,
                                  32'h0, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_IDR,
                                  32'h0, 16'hFFFF));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_IDR,
                                  32'hFFFF_FFFF, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_IDR,
                                  32'hFFFF_FFFF, 16'h5A5A));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_ODR,
                                  32'hFFFF_FFFF, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_ODR,
                                  32'h0, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_BSRR,
                                  32'hFFFF_0000, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_BSRR,
                                  32'hFFFF_FFFF, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_BSRR,
                                  32'h00FF_A5A5, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_BSRR,
                                  32'h0, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_BRR,
                                  32'hFFFF_000F, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_BRR,
                                  32'h0, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_UNUSED,
                                  32'hFFFF_FFFF, 16'hFFFF));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_UNUSED,
                                  32'hFFFF_FFFF, 16'hFFFF));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_LCKR,
                                  32'hFFFF_FFFF, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_LCKR,
                                  32'h0, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_WRITE, gpl_pkg::SEL_LCKR,
                                  32'hFFFE_0000, 16'h0));
        pending_acc.push_back(acc(gpl_pkg::OP_READ,  gpl_pkg::SEL_LCKR,
                                  32'h0, 16'h0));

        // unlocked traffic with broken lock sequences
        while (pending_acc.size() < UNLOCKED_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_lock_seq(1'b0);
            else
                pending_acc.push_back(any_access(1'b1));
        end
        queue_lock_seq(1'b1);

        // locked: hammer the configuration words and retry the lock register
        while (pending_acc.size() < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: queue_lock_seq($urandom_range(0, 1));
                1, 2, 3, 4:
                begin
                    pending_acc.push_back(acc(gpl_pkg::OP_WRITE, 3'($urandom_range(0, 1)),
                                              $urandom(), 16'($urandom())));
                    pending_acc.push_back(acc(gpl_pkg::OP_READ, 3'($urandom_range(0, 1)),
                                              $urandom(), 16'($urandom())));
                end
                default: pending_acc.push_back(any_access(1'b1));
            endcase
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_acc.size() != 0 || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            errors++;
            $display("%0t: %0d items still expected, actual none", $time,
                     expected_rsp.size());
        end
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
